/* hw/rtl/mi3_pkg.sv */
package mi3_pkg;

    // default element format, Q16.16
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // configuration register
    localparam int THR_W   = 31;
    localparam int CFG_DW  = 32;
    localparam int ADDR_W  = 3;
    localparam int REG_THR = 0;

    // signed width of the exact determinant
    function automatic int det_w(input int w);
        return 3 * w + 3;
    endfunction

    // unsigned width of the divider numerator and remainder
    function automatic int num_w(input int w, input int f);
        int a;
        int b;
        a = 2 * w + 2 * f + 2;
        b = 3 * w + 3;
        return ((a > b) ? a : b) + 1;
    endfunction

endpackage

/* hw/rtl/mi3_cofactor.sv */
module mi3_cofactor #(
    parameter int ELEM_WIDTH = 32
) (
    input  logic                                           i_clk,
    input  logic                                           i_en,
    input  logic [9*ELEM_WIDTH-1:0]                        i_mat,
    output logic signed [mi3_pkg::det_w(ELEM_WIDTH)-1:0]   o_det,
    output logic signed [2*ELEM_WIDTH:0]                   o_cof [9]
);
    import mi3_pkg::*;

    localparam int W  = ELEM_WIDTH;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int DW = det_w(W);

    // operand pairs: cofactor k = prod[2k] - prod[2k+1]
    localparam int PA [18] = '{4, 7, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 6, 1, 0, 0, 1};
    localparam int PB [18] = '{8, 5, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 4, 6, 7, 4, 3};

    logic signed [W-1:0]  a [9];
    logic signed [PW-1:0] r_p [18];
    logic signed [W-1:0]  r_a1 [3];
    logic signed [W-1:0]  r_a2 [3];
    logic signed [CW-1:0] r_c2 [9];
    logic signed [CW-1:0] r_c3 [9];
    logic signed [CW-1:0] r_c4 [9];
    logic signed [CW-1:0] r_pl [3];
    logic signed [CW-1:0] r_ph [3];
    logic signed [DW-1:0] n_det;
    logic signed [DW-1:0] r_det;

    // unpack row-major elements
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            a[k] = $signed(i_mat[k*W +: W]);
        end
    end

    // stage 1: eighteen 2x2 minor products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 18; j++) begin
                r_p[j] <= a[PA[j]] * a[PB[j]];
            end
            for (int k = 0; k < 3; k++) begin
                r_a1[k] <= a[k];
            end
        end
    end

    // stage 2: cofactors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                r_c2[k] <= CW'(r_p[2*k]) - CW'(r_p[2*k+1]);
            end
            r_a2 <= r_a1;
        end
    end

    // stage 3: first-row terms split into low and high partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pl[k] <= r_a2[k] * $signed({1'b0, r_c2[3*k][W-1:0]});
                r_ph[k] <= r_a2[k] * $signed(r_c2[3*k][CW-1:W]);
            end
            r_c3 <= r_c2;
        end
    end

    // stage 4: determinant
    always_comb begin
        n_det = '0;
        for (int k = 0; k < 3; k++) begin
            n_det = n_det + (DW'(r_ph[k]) <<< W) + DW'(r_pl[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= n_det;
            r_c4  <= r_c3;
        end
    end

    assign o_det = r_det;
    assign o_cof = r_c4;

endmodule

/* hw/rtl/mi3_div.sv */
module mi3_div #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                                i_clk,
    input  logic                                                i_en,
    input  logic [mi3_pkg::num_w(ELEM_WIDTH, FRAC_BITS)-1:0]    i_num,
    input  logic [mi3_pkg::num_w(ELEM_WIDTH, FRAC_BITS)-1:0]    i_den,
    input  logic                                                i_neg,
    output logic signed [ELEM_WIDTH-1:0]                        o_q
);
    import mi3_pkg::*;

    localparam int W  = ELEM_WIDTH;
    localparam int NW = num_w(ELEM_WIDTH, FRAC_BITS);

    logic [NW-1:0] r_rem [W];
    logic [NW-1:0] r_den [W];
    logic [W-1:0]  r_q   [W+1];
    logic          r_big [W+1];
    logic          r_neg [W+1];
    logic [W:1]    take;

    // one restoring compare per stage, most significant quotient bit first
    always_comb begin
        for (int k = 1; k <= W; k++) begin
            take[k] = (r_rem[k-1] >> (W - k)) >= r_den[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // entry stage: quotient overflow check, the result then saturates
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_big[0] <= (i_num >> W) >= i_den;
            r_neg[0] <= i_neg;
            // step stages
            for (int k = 1; k <= W; k++) begin
                r_q[k]   <= r_q[k-1] | (W'(take[k]) << (W - k));
                r_big[k] <= r_big[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 1; k < W; k++) begin
                r_rem[k] <= take[k] ? r_rem[k-1] - (r_den[k-1] << (W - k)) : r_rem[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    // sign and saturation
    always_comb begin
        if (r_big[W] || r_q[W][W-1]) begin
            o_q = r_neg[W] ? $signed({1'b1, {(W-1){1'b0}}}) : $signed({1'b0, {(W-1){1'b1}}});
        end else begin
            o_q = r_neg[W] ? $signed(-r_q[W]) : $signed(r_q[W]);
        end
    end

endmodule

/* hw/rtl/matrix3x3_inverse.sv */
// Throughput: one matrix per cycle while the output is not stalled; set by the fully
// pipelined datapath of four product/sum stages, one magnitude stage and nine
// ELEM_WIDTH+1 stage dividers. The whole pipeline holds while a result waits and
// m_axis_tready is low.
// Reset (i_rst_n low, synchronous) clears all valid bits and the threshold.
module matrix3x3_inverse #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // a00 a01 a02 a10 a11 a12 a20 a21 a22, ELEM_WIDTH each, from bit 0
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // inv00 .. inv22, determinant, ELEM_WIDTH each, from bit 0
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((10*ELEM_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // singular
    output logic [0:0]                             m_axis_tuser,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mi3_pkg::ADDR_W-1:0]             paddr,
    input  logic [mi3_pkg::CFG_DW-1:0]             pwdata,
    output logic [mi3_pkg::CFG_DW-1:0]             prdata,
    output logic                                   pready
);
    import mi3_pkg::*;

    localparam int W    = ELEM_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int CW   = 2 * W + 1;
    localparam int DW   = det_w(W);
    localparam int NW   = num_w(W, F);
    localparam int XW   = DW + 2;
    localparam int CMPW = (DW > THR_W + 2 * F) ? DW : THR_W + 2 * F;
    localparam int L    = W + 7;

    logic                 en;
    logic [L-1:0]         r_vld;
    logic [THR_W-1:0]     r_thr;
    logic                 reg_sel;

    logic signed [DW-1:0] det4;
    logic signed [CW-1:0] cof4 [9];

    logic [DW-1:0]        r_adet;
    logic                 r_dneg;
    logic [CW-1:0]        r_cabs [9];
    logic                 r_cneg [9];

    logic                 n_sing;
    logic [XW-1:0]        rd;
    logic signed [W-1:0]  n_dsat;
    logic [NW-1:0]        num [9];
    logic [NW-1:0]        den;
    logic signed [W-1:0]  quo [9];

    logic                 r_sd_sing [W+1];
    logic signed [W-1:0]  r_sd_det  [W+1];

    logic signed [W-1:0]  r_out_inv [9];
    logic signed [W-1:0]  r_out_det;
    logic                 r_out_sing;

    // configuration port
    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2] == (ADDR_W-2)'(REG_THR);
    assign prdata  = reg_sel ? CFG_DW'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    // pipeline advance and valid bits
    assign en            = !r_vld[L-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], s_axis_tvalid};
        end
    end

    // stages 1-4: cofactors and determinant
    mi3_cofactor #(
        .ELEM_WIDTH (W)
    ) u_cof (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mat (s_axis_tdata[9*W-1:0]),
        .o_det (det4),
        .o_cof (cof4)
    );

    // stage 5: magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_adet <= det4[DW-1] ? DW'(-det4) : DW'(det4);
            r_dneg <= det4[DW-1];
            for (int k = 0; k < 9; k++) begin
                r_cabs[k] <= cof4[k][CW-1] ? CW'(-cof4[k]) : CW'(cof4[k]);
                r_cneg[k] <= cof4[k][CW-1];
            end
        end
    end

    // singular test and rounded, saturated determinant
    always_comb begin
        n_sing = CMPW'(r_adet) <= (CMPW'(r_thr) << (2 * F));
        rd     = (XW'(r_adet) + (XW'(1) << (2 * F - 1))) >> (2 * F);
        if (rd >= (XW'(1) << (W - 1))) begin
            n_dsat = r_dneg ? $signed({1'b1, {(W-1){1'b0}}})
                            : $signed({1'b0, {(W-1){1'b1}}});
        end else begin
            n_dsat = r_dneg ? $signed(-rd[W-1:0]) : $signed(rd[W-1:0]);
        end
    end

    // divider operands: rounded quotient (2|c|*2^2F + |det|) / (2|det|)
    assign den = NW'(r_adet) << 1;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            num[k] = (NW'(r_cabs[k]) << (2 * F + 1)) + NW'(r_adet);
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_div
        mi3_div #(
            .ELEM_WIDTH (W),
            .FRAC_BITS  (F)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (num[k]),
            .i_den (den),
            .i_neg (r_cneg[k] ^ r_dneg),
            .o_q   (quo[k])
        );
    end

    // side line alongside the dividers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd_sing[0] <= n_sing;
            r_sd_det[0]  <= n_dsat;
            for (int k = 1; k <= W; k++) begin
                r_sd_sing[k] <= r_sd_sing[k-1];
                r_sd_det[k]  <= r_sd_det[k-1];
            end
        end
    end

    // output register, inverse forced to zero when singular
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_out_inv[k] <= r_sd_sing[W] ? '0 : quo[k];
            end
            r_out_det  <= r_sd_det[W];
            r_out_sing <= r_sd_sing[W];
        end
    end

    always_comb begin
        m_axis_tdata = '0;
        for (int k = 0; k < 9; k++) begin
            m_axis_tdata[k*W +: W] = r_out_inv[k];
        end
        m_axis_tdata[9*W +: W] = r_out_det;
    end

    assign m_axis_tuser = r_out_sing;

endmodule

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mi3_pkg::*;

    localparam int EW = 32;
    localparam int FB = 16;
    localparam int LATENCY = EW + 7;
    localparam int N_RANDOM = 830;

    typedef logic signed [EW-1:0] elem_t;

    typedef struct packed {
        logic  singular;
        elem_t det;
        elem_t [8:0] inv;
    } inv_result_t;

    typedef struct {
        elem_t       m [9];
        logic        known;
        inv_result_t res;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [9*EW-1:0] s_axis_tdata;   // a00 a01 a02 a10 a11 a12 a20 a21 a22, from bit 0
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [10*EW-1:0] m_axis_tdata;  // inv00 .. inv22, determinant, from bit 0
    logic [0:0] m_axis_tuser;        // singular
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic pready;

    inv_result_t expected_q[$];
    logic [THR_W-1:0] threshold;
    int errors;
    bit rx_stall_mode;

    matrix3x3_inverse DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // saturate a magnitude to the element range with sign
    function automatic elem_t sat_round(input logic [255:0] mag, input bit neg);
        if (neg) begin
            if (mag >= 256'(1) << (EW - 1))
                return {1'b1, {(EW-1){1'b0}}};
            return elem_t'(-$signed({1'b0, mag[EW-1:0]}));
        end
        if (mag > (256'(1) << (EW - 1)) - 1)
            return {1'b0, {(EW-1){1'b1}}};
        return elem_t'(mag[EW-1:0]);
    endfunction

    // exact cofactor inverse of one matrix under the current threshold
    function automatic inv_result_t invert_matrix(input elem_t m [9]);
        inv_result_t r;
        logic signed [255:0] a [9];
        logic signed [255:0] c [9];
        logic signed [255:0] d;
        logic [255:0] ad, ac, num, den, lim;
        bit sing;
        for (int i = 0; i < 9; i++) a[i] = 256'(m[i]);
        c[0] = a[4]*a[8] - a[7]*a[5];
        c[1] = a[2]*a[7] - a[1]*a[8];
        c[2] = a[1]*a[5] - a[2]*a[4];
        c[3] = a[5]*a[6] - a[3]*a[8];
        c[4] = a[0]*a[8] - a[2]*a[6];
        c[5] = a[2]*a[3] - a[0]*a[5];
        c[6] = a[3]*a[7] - a[6]*a[4];
        c[7] = a[1]*a[6] - a[0]*a[7];
        c[8] = a[0]*a[4] - a[1]*a[3];
        d = a[0]*c[0] + a[1]*c[3] + a[2]*c[6];
        ad = d < 0 ? -d : d;
        lim = 256'(threshold) << (2 * FB);
        sing = ad <= lim;
        r.det = sat_round((ad + (256'(1) << (2*FB - 1))) >> (2*FB), d < 0);
        r.singular = sing;
        den = ad << 1;
        for (int i = 0; i < 9; i++) begin
            if (sing) begin
                r.inv[i] = '0;
            end else begin
                ac = c[i] < 0 ? -c[i] : c[i];
                num = (ac << (2*FB + 1)) + ad;
                r.inv[i] = sat_round(num / den, (c[i] < 0) != (d < 0));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [EW-1:0] got,
                                   input logic [EW-1:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $display("%0t result transfer with nothing expected", $realtime);
                errors++;
            end else begin
                inv_result_t e;
                e = expected_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_axis_tdata[i*EW +: EW] !== e.inv[i])
                        report_mismatch($sformatf("inv%0d%0d", i/3, i%3),
                                        m_axis_tdata[i*EW +: EW], e.inv[i]);
                if (m_axis_tdata[9*EW +: EW] !== e.det)
                    report_mismatch("determinant", m_axis_tdata[9*EW +: EW], e.det);
                if (m_axis_tuser[0] !== e.singular)
                    report_mismatch("singular", EW'(m_axis_tuser[0]), EW'(e.singular));
            end
        end
        if ($urandom_range(0, 99) < 3) rx_stall_mode <= ~rx_stall_mode;
        m_axis_tready <= rx_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    task automatic write_threshold(input logic [THR_W-1:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(REG_THR * 4); pwdata <= {1'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        threshold = v;
    endtask

    task automatic drain;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // send one matrix; tvalid stays up across back-to-back transfers,
    // otherwise it drops before the next matrix is offered
    task automatic send_matrix(input elem_t m [9], input bit keep);
        for (int i = 0; i < 9; i++) s_axis_tdata[i*EW +: EW] <= m[i];
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(invert_matrix(m));
        if (!keep) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic elem_t rand_elem(input int kind);
        case (kind)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 4 << FB)) - (2 << FB));
            2: return elem_t'($signed($urandom_range(0, 512)) - 256);
            3: return $urandom_range(0, 1) ? {1'b0, {(EW-1){1'b1}}} : {1'b1, {(EW-1){1'b0}}};
            default: return '0;
        endcase
    endfunction

    dir_row_t dir_rows[$];

    task automatic add_row(input elem_t m [9]);
        dir_row_t r;
        r.m = m;
        r.known = 1'b0;
        dir_rows.push_back(r);
    endtask

    initial begin
        elem_t m [9];
        elem_t one_q, mx, mn;
        dir_row_t r;
        int burst;
        int sent;
        errors = 0;
        threshold = '0;
        rx_stall_mode = 1'b0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        one_q = elem_t'(1 << FB);
        mx = {1'b0, {(EW-1){1'b1}}};
        mn = {1'b1, {(EW-1){1'b0}}};

        // directed table: zero matrix (singular, known), identity (known), extremes
        m = '{default: '0};
        r.m = m; r.known = 1'b1; r.res = '0; r.res.singular = 1'b1;
        dir_rows.push_back(r);
        m = '{one_q, 0, 0, 0, one_q, 0, 0, 0, one_q};
        r.m = m; r.known = 1'b1; r.res = '0; r.res.det = one_q;
        r.res.inv[0] = one_q; r.res.inv[4] = one_q; r.res.inv[8] = one_q;
        dir_rows.push_back(r);
        m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};       add_row(m);
        m = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};       add_row(m);
        m = '{mx, mn, 1, -1, mx, mn, mn, 1, mx};   add_row(m);
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};          add_row(m);
        m = '{2, 1, 0, 1, 2, 1, 0, 1, 2};          add_row(m);
        m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};         add_row(m);
        m = '{one_q, 2*one_q, 3*one_q, 4*one_q, 5*one_q, 6*one_q,
              7*one_q, 8*one_q, 10*one_q};         add_row(m);
        m = '{one_q, 2*one_q, 3*one_q, 4*one_q, 5*one_q, 6*one_q,
              7*one_q, 8*one_q, 9*one_q};          add_row(m);
        m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; add_row(m);
        m = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};       add_row(m);
        m = '{3, 0, 0, 0, 3, 0, 0, 0, 3};          add_row(m);

        foreach (dir_rows[k]) begin
            send_matrix(dir_rows[k].m, 1'b0);
            if (dir_rows[k].known && expected_q[$] !== dir_rows[k].res) begin
                $display("directed row %0d: predictor disagrees with table", k);
                errors++;
            end
        end
        drain();

        // near-tiny determinants across threshold settings, extremes included
        for (int t = 0; t < 4; t++) begin
            case (t)
                0: write_threshold(31'd1);
                1: write_threshold(31'd5);
                2: write_threshold({THR_W{1'b1}});
                default: write_threshold('0);
            endcase
            m = '{one_q, 0, 0, 0, one_q, 0, 0, 0, one_q}; send_matrix(m, 1'b0);
            m = '{2*one_q, 0, 0, 0, 2*one_q, 0, 0, 0, one_q + one_q/4};
            send_matrix(m, 1'b0);
            m = '{mx, 0, 0, 0, mx, 0, 0, 0, mx}; send_matrix(m, 1'b0);
            drain();
        end

        // random bursts, threshold changes between phases
        sent = 0;
        while (sent < N_RANDOM) begin
            if (sent % 200 == 199) begin
                drain();
                write_threshold($urandom_range(0, 3) == 0 ? THR_W'($urandom)
                                                          : THR_W'($urandom_range(0, 8)));
            end
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
                int kind;
                kind = $urandom_range(0, 9);
                for (int i = 0; i < 9; i++)
                    m[i] = rand_elem(kind < 3 ? 0 : kind < 7 ? 1 : kind < 9 ? 2
                                     : $urandom_range(0, 4));
                send_matrix(m, b + 1 < burst && sent + 1 < N_RANDOM);
                sent++;
            end
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_cofactor.sv
hw/rtl/mi3_div.sv
hw/rtl/matrix3x3_inverse.sv
test/tb.sv
